FILE: design/pcf_pkg.sv
// Package for the PNG chunk framer: job word layout, CRC-32 helpers and sizes.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps

package pcf_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          STEP_W      = 4;

    localparam logic [STEP_W-1:0] STEP_BEGIN_LAST       = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_BEGIN_CLOSE_LAST = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_DATA_CLOSE_LAST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_SINGLE_LAST      = STEP_W'(0);

    typedef enum logic [1:0] {
        KIND_BEGIN,
        KIND_DATA,
        KIND_STRAY
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        err;
        logic        close;
        logic [31:0] len_word;
        logic [31:0] type_word;
        logic [31:0] crc_out;
        logic [7:0]  data;
    } job_t;

    function automatic logic [31:0] crc_fold8(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_fold32(input logic [31:0] c_in, input logic [31:0] w);
        logic [31:0] c;
        c = c_in;
        c = crc_fold8(c, w[31:24]);
        c = crc_fold8(c, w[23:16]);
        c = crc_fold8(c, w[15:8]);
        c = crc_fold8(c, w[7:0]);
        return c;
    endfunction

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd3:    b = w[31:24];
            2'd2:    b = w[23:16];
            2'd1:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: design/pcf_front.sv
// Front end of the PNG chunk framer: classifies words, runs chunk state and CRC.
// Depends on pcf_pkg; feeds job words to pcf_queue.
`timescale 1ns / 1ps

module pcf_front
    import pcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        req_type,
    input  logic [31:0] chunk_type,
    input  logic [30:0] chunk_length,
    input  logic [7:0]  data_byte,
    output job_t        job
);

    logic [31:0] crc_reg,  crc_next;
    logic [30:0] rem_reg,  rem_next;
    logic        open_reg, open_next;

    logic [31:0] crc_type;
    logic [31:0] crc_data;

    assign crc_type = crc_fold32(CRC_PRESET, chunk_type);
    assign crc_data = crc_fold8(crc_reg, data_byte);

    always_comb
    begin
        job           = '0;
        job.kind      = KIND_STRAY;
        job.len_word  = {1'b0, chunk_length};
        job.type_word = chunk_type;
        job.data      = data_byte;
        crc_next      = crc_reg;
        rem_next      = rem_reg;
        open_next     = open_reg;
        if (!req_type)
        begin
            job.kind    = KIND_BEGIN;
            job.err     = open_reg;
            job.close   = (chunk_length == '0);
            job.crc_out = ~crc_type;
            if (job.close)
            begin
                crc_next  = CRC_PRESET;
                rem_next  = '0;
                open_next = 1'b0;
            end
            else
            begin
                crc_next  = crc_type;
                rem_next  = chunk_length;
                open_next = 1'b1;
            end
        end
        else if (!open_reg)
        begin
            job.kind = KIND_STRAY;
            job.err  = 1'b1;
            job.data = '0;
        end
        else
        begin
            job.kind    = KIND_DATA;
            job.close   = (rem_reg == 31'd1);
            job.crc_out = ~crc_data;
            if (job.close)
            begin
                crc_next  = CRC_PRESET;
                rem_next  = '0;
                open_next = 1'b0;
            end
            else
            begin
                crc_next = crc_data;
                rem_next = rem_reg - 31'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_PRESET;
            rem_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            crc_reg  <= crc_next;
            rem_reg  <= rem_next;
            open_reg <= open_next;
        end
    end

    a_closed_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (rem_reg == '0))
        else $error("closed chunk with bytes remaining");

    a_open_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (rem_reg != '0))
        else $error("open chunk with no bytes remaining");

    a_closed_crc_preset: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (crc_reg == CRC_PRESET))
        else $error("CRC not preset while no chunk open");

endmodule

FILE: design/pcf_queue.sv
// Job queue between front and back of the PNG chunk framer.
// Depends on pcf_pkg; register-based FIFO with head shown combinationally.
`timescale 1ns / 1ps

module pcf_queue
    import pcf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_full,
    output logic q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: design/pcf_back.sv
// Back end of the PNG chunk framer: steps through each job, one output byte per cycle
// when a job waits and output is free. Depends on pcf_pkg; reads jobs from pcf_queue, drives the output register.
`timescale 1ns / 1ps

module pcf_back
    import pcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       chunk_end,
    output logic       run_last,
    output logic       protocol_error
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg;
    logic              end_reg;
    logic              last_reg;
    logic              err_reg;

    logic [STEP_W-1:0] last_step;
    logic              is_last;
    logic              emit_go;
    logic [7:0]        cur_byte;

    always_comb
    begin
        case (head.kind)
            KIND_BEGIN: last_step = head.close ? STEP_BEGIN_CLOSE_LAST : STEP_BEGIN_LAST;
            KIND_DATA:  last_step = head.close ? STEP_DATA_CLOSE_LAST : STEP_SINGLE_LAST;
            default:    last_step = STEP_SINGLE_LAST;
        endcase
    end

    always_comb
    begin
        case (head.kind)
            KIND_BEGIN:
            begin
                if (step_reg < STEP_W'(4))
                    cur_byte = byte_of(head.len_word, 2'(STEP_W'(3) - step_reg));
                else if (step_reg < STEP_W'(8))
                    cur_byte = byte_of(head.type_word, 2'(STEP_W'(7) - step_reg));
                else
                    cur_byte = byte_of(head.crc_out, 2'(STEP_W'(11) - step_reg));
            end
            KIND_DATA:
            begin
                if (step_reg == '0)
                    cur_byte = head.data;
                else
                    cur_byte = byte_of(head.crc_out, 2'(STEP_W'(4) - step_reg));
            end
            default: cur_byte = '0;
        endcase
    end

    assign is_last = (step_reg == last_step);
    assign emit_go = !q_empty && (!valid_reg || pop);
    assign q_pop   = emit_go && is_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (emit_go)
        begin
            step_next  = is_last ? '0 : step_reg + STEP_W'(1);
            valid_next = 1'b1;
        end
        else if (pop && valid_reg)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            byte_reg <= cur_byte;
            end_reg  <= is_last && head.close;
            last_reg <= is_last;
            err_reg  <= head.err;
        end
    end

    assign empty          = !valid_reg;
    assign out_byte       = byte_reg;
    assign chunk_end      = end_reg;
    assign run_last       = last_reg;
    assign protocol_error = err_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_BEGIN_CLOSE_LAST)
        else $error("step counter out of range");

    a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> !q_empty)
        else $error("mid-job step with empty queue");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg) |-> last_reg)
        else $error("chunk end not on last word of item");

endmodule

FILE: design/png_chunk_framer_crc32_top.sv
// Top level of the PNG chunk framer with CRC-32.
// Depends on pcf_pkg, pcf_front, pcf_queue, pcf_back.
//
//  channel  | handshake        | fields
//  ---------+------------------+-----------------------------------------------
//  input    | push / full      | req_type, chunk_type, chunk_length, data_byte
//  result   | pop / empty      | out_byte, chunk_end, run_last, protocol_error
//
// One input word is taken per cycle while the job queue has room.
// The back end emits one result word per cycle while jobs wait and pop allows: a begin gives 8 words (12 for an
// empty chunk), a data byte 1 (5 when it closes the chunk), a stray byte 1.
// An accepted word enters the job queue; its first result is then loaded into the output register.
// Reset clears chunk state, the job queue and the output valid flag at once; output data is not reset.
// A stalled result side fills the queue; full rises once QDEPTH jobs wait in it.
`timescale 1ns / 1ps

module png_chunk_framer_crc32_top
    import pcf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [31:0] chunk_type,
    input  logic [30:0] chunk_length,
    input  logic [7:0]  data_byte,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        chunk_end,
    output logic        run_last,
    output logic        protocol_error
);

    logic accept;
    job_t front_job;
    job_t head_job;
    logic q_pop;
    logic q_empty;

    assign accept = push && !full;

    pcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .chunk_type   (chunk_type),
        .chunk_length (chunk_length),
        .data_byte    (data_byte),
        .job          (front_job)
    );

    pcf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_job  (front_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_full  (full),
        .q_empty (q_empty)
    );

    pcf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head_job),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .out_byte       (out_byte),
        .chunk_end      (chunk_end),
        .run_last       (run_last),
        .protocol_error (protocol_error)
    );

endmodule

FILE: sim/png_chunk_framer_crc32_top_tb.sv
// Testbench for png_chunk_framer_crc32_top: directed and random chunk traffic,
// with a scoreboard class that predicts the framed byte stream and CRC-32.
// Depends on pcf_pkg and the framer RTL.
`timescale 1ns / 1ps

module png_chunk_framer_crc32_top_tb;
    import pcf_pkg::*;

    localparam bit REQ_BEGIN  = 1'b0;
    localparam bit REQ_DATA   = 1'b1;
    localparam int HOLD_LEN   = 80;
    localparam int DOG_LIMIT  = 2000;
    localparam int TAIL_WAIT  = 20;
    localparam int PHASE_WORDS = 100;

    typedef struct packed {
        logic [7:0] ob;
        logic       ends;
        logic       tail;
        logic       err;
    } frame_word_t;

    class chunk_crc_scoreboard;
        bit [31:0]   crc;
        bit [30:0]   left;
        bit          open;
        frame_word_t want[$];
        int          errors;
        int          checked;
        int          closes;
        int          strays;
        int          abandons;

        function new();
            crc = CRC_PRESET;
            left = '0;
            open = 1'b0;
        endfunction

        function bit [31:0] fold(bit [31:0] c, bit [7:0] b);
            bit [31:0] v;
            v = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
            return v;
        endfunction

        function void put(bit [7:0] b, bit e, bit err);
            frame_word_t w;
            w.ob = b;
            w.ends = e;
            w.tail = 1'b0;
            w.err = err;
            want.insert(want.size(), w);
        endfunction

        function void put_word(bit [31:0] w, bit e, bit err);
            for (int s = 3; s >= 0; s--)
                put(w[8*s +: 8], e && s == 0, err);
        endfunction

        function void close_chunk(bit err);
            put_word(~crc, 1'b1, err);
            crc = CRC_PRESET;
            left = '0;
            open = 1'b0;
            closes++;
        endfunction

        function void note(bit req, bit [31:0] ty, bit [30:0] len, bit [7:0] db);
            bit err;
            if (req == REQ_BEGIN)
            begin
                err = open;
                if (err)
                    abandons++;
                put_word({1'b0, len}, 1'b0, err);
                put_word(ty, 1'b0, err);
                crc = CRC_PRESET;
                for (int s = 3; s >= 0; s--)
                    crc = fold(crc, ty[8*s +: 8]);
                left = len;
                open = 1'b1;
                if (len == 0)
                    close_chunk(err);
            end
            else if (!open)
            begin
                put(8'd0, 1'b0, 1'b1);
                strays++;
            end
            else
            begin
                put(db, 1'b0, 1'b0);
                crc = fold(crc, db);
                left = left - 31'd1;
                if (left == 0)
                    close_chunk(1'b0);
            end
            want[want.size() - 1].tail = 1'b1;
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t ERROR %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(logic [7:0] ob, logic ends, logic tail, logic err);
            frame_word_t w;
            if (want.size() == 0)
            begin
                $display("%0t ERROR unexpected result word: expected none, actual %02h %b%b%b",
                         $time, ob, ends, tail, err);
                errors++;
                return;
            end
            w = want.pop_front();
            checked++;
            cmp("out_byte", 32'(w.ob), 32'(ob));
            cmp("chunk_end", 32'(w.ends), 32'(ends));
            cmp("run_last", 32'(w.tail), 32'(tail));
            cmp("protocol_error", 32'(w.err), 32'(err));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        req_type;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
    logic        pop;
    logic        empty;
    logic [7:0]  out_byte;
    logic        chunk_end;
    logic        run_last;
    logic        protocol_error;

    chunk_crc_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_ack;
    int sent_words;
    int quiet_cycles = 0;

    png_chunk_framer_crc32_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req_type(req_type),
        .chunk_type(chunk_type),
        .chunk_length(chunk_length),
        .data_byte(data_byte),
        .pop(pop),
        .empty(empty),
        .out_byte(out_byte),
        .chunk_end(chunk_end),
        .run_last(run_last),
        .protocol_error(protocol_error)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // called right after a falling edge; returns right after a falling edge
    task automatic send_word(bit req, bit [31:0] ty, bit [30:0] len, bit [7:0] db);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        req_type <= req;
        chunk_type <= ty;
        chunk_length <= len;
        data_byte <= db;
        do
            @(posedge clk);
        while (full);
        sb.note(req, ty, len, db);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_begin(bit [31:0] ty, bit [30:0] len);
        send_word(REQ_BEGIN, ty, len, 8'($urandom));
    endtask

    task automatic send_data(bit [7:0] db);
        send_word(REQ_DATA, $urandom, 31'($urandom), db);
    endtask

    task automatic drain();
        push <= 1'b0;
        do
            @(negedge clk);
        while (sb.want.size() != 0);
    endtask

    task automatic random_chunks(int words);
        int stop_at;
        int r;
        int n_send;
        bit [30:0] len;
        stop_at = sent_words + words;
        while (sent_words < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                send_data(8'($urandom));
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 60)
                    len = 31'($urandom_range(0, 6));
                else if (r < 90)
                    len = 31'($urandom_range(7, 24));
                else
                    len = 31'($urandom);
                if (len > 24)
                    n_send = $urandom_range(0, 10);
                else if (len > 0 && $urandom_range(99) < 15)
                    n_send = $urandom_range(0, len - 1);
                else
                    n_send = int'(len);
                if (n_send > stop_at - sent_words - 1)
                    n_send = stop_at - sent_words - 1;
                send_begin($urandom, len);
                repeat (n_send)
                    send_data(8'($urandom));
            end
        end
    endtask

    // result side: long hold on request, otherwise random idling
    initial
    begin
        pop = 1'b0;
        hold_ack = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                repeat (HOLD_LEN)
                begin
                    pop <= 1'b0;
                    @(negedge clk);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check(out_byte, chunk_end, run_last, protocol_error);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT)
        begin
            $display("%0t ERROR watchdog: no handshake for %0d cycles", $time, DOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        req_type = REQ_BEGIN;
        chunk_type = '0;
        chunk_length = '0;
        data_byte = '0;
        hold_req = 0;
        sent_words = 0;
        send_idle_pct = 12;
        recv_idle_pct = 54;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty chunk, strays, extremes, abandon cases
        send_begin(32'h49454E44, 31'd0);
        send_data(8'hFF);
        send_data(8'h00);
        send_begin(32'h00000000, 31'd1);
        send_data(8'hFF);
        send_begin(32'hFFFFFFFF, 31'd2);
        send_data(8'hA5);
        send_begin(32'h49444154, 31'h7FFFFFFF);
        send_data(8'h5A);
        send_begin(32'h74455874, 31'd0);
        send_begin(32'h49484452, 31'd3);
        send_data(8'h00);
        send_data(8'h80);
        send_data(8'h01);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 12 : 0;
            if (ph == 0)
                hold_req = hold_req + 1;
            random_chunks(PHASE_WORDS);
            drain();
        end

        repeat (TAIL_WAIT) @(negedge clk);
        $display("run: %0d input words, %0d result words checked", sent_words, sb.checked);
        $display("run: %0d chunks closed, %0d stray bytes, %0d chunks abandoned",
                 sb.closes, sb.strays, sb.abandons);
        if (sb.errors == 0 && sb.want.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
